// File: rtl/ctt_pkg.sv
// Shared types, character codes and classification functions for the config text tokenizer.
package ctt_pkg;

    // Result queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    // Scanner modes, one-hot
    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_SLASH = 8'b0000_0010,
        MODE_WORD  = 8'b0000_0100,
        MODE_QOPEN = 8'b0000_1000,
        MODE_QUOTE = 8'b0001_0000,
        MODE_LINE  = 8'b0010_0000,
        MODE_BLOCK = 8'b0100_0000,
        MODE_BSTAR = 8'b1000_0000
    } mode_t;

    // One result item
    typedef struct packed {
        logic [7:0] token_byte;
        logic       token_last;
        logic       token_quoted;
        logic       token_empty;
    } token_t;

    // Results produced by one scanned byte
    typedef struct packed {
        logic [1:0] num;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // One-character tokens
    function automatic logic is_single(input logic [7:0] c);
        return c inside {CH_COMMA, CH_LBRACE, CH_RBRACE, CH_RPAREN, CH_LPAREN,
                         CH_SQUOTE, CH_COLON, CH_SEMI, CH_EQ, CH_BANG,
                         CH_GT, CH_LT, CH_AMP, CH_PIPE, CH_PLUS};
    endfunction

    // Word bytes: printable, not a one-character token
    function automatic logic is_word(input logic [7:0] c);
        return (c > CH_SPACE) && (c < CH_HIGH) && !is_single(c);
    endfunction

endpackage

// File: rtl/ctt_scan.sv
// Mode machine that scans one byte per cycle while room is high and yields up to two tokens.
module ctt_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [7:0]      item_byte,
    input  logic            room,
    output ctt_pkg::push_t  push
);

    ctt_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     held_byte_reg, held_byte_next;
    ctt_pkg::push_t res;
    logic           fire;

    assign fire = item_valid && room;

    // Next mode and results for the byte in the input register
    always_comb
    begin
        logic [7:0] c;
        c              = item_byte;
        mode_next      = mode_reg;
        held_byte_next = held_byte_reg;
        res            = '0;

        case (mode_reg)
            ctt_pkg::MODE_IDLE:
            begin
                if (c == ctt_pkg::CH_SLASH)
                begin
                    held_byte_next = c;
                    mode_next      = ctt_pkg::MODE_SLASH;
                end
                else if (c == ctt_pkg::CH_DQUOTE)
                begin
                    mode_next = ctt_pkg::MODE_QOPEN;
                end
                else if (ctt_pkg::is_single(c))
                begin
                    res.num  = 2'd1;
                    res.tok0 = '{token_byte: c, token_last: 1'b1,
                                 token_quoted: 1'b0, token_empty: 1'b0};
                end
                else if (ctt_pkg::is_word(c))
                begin
                    held_byte_next = c;
                    mode_next      = ctt_pkg::MODE_WORD;
                end
            end

            ctt_pkg::MODE_SLASH, ctt_pkg::MODE_WORD:
            begin
                if (mode_reg == ctt_pkg::MODE_SLASH && c == ctt_pkg::CH_SLASH)
                begin
                    mode_next = ctt_pkg::MODE_LINE;
                end
                else if (mode_reg == ctt_pkg::MODE_SLASH && c == ctt_pkg::CH_STAR)
                begin
                    mode_next = ctt_pkg::MODE_BLOCK;
                end
                else if (ctt_pkg::is_word(c))
                begin
                    // continue the word: release the held byte, hold the new one
                    res.num        = 2'd1;
                    res.tok0       = '{token_byte: held_byte_reg, token_last: 1'b0,
                                       token_quoted: 1'b0, token_empty: 1'b0};
                    held_byte_next = c;
                    mode_next      = ctt_pkg::MODE_WORD;
                end
                else if (ctt_pkg::is_single(c))
                begin
                    // close the word, then the one-character token
                    res.num   = 2'd2;
                    res.tok0  = '{token_byte: held_byte_reg, token_last: 1'b1,
                                  token_quoted: 1'b0, token_empty: 1'b0};
                    res.tok1  = '{token_byte: c, token_last: 1'b1,
                                  token_quoted: 1'b0, token_empty: 1'b0};
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else
                begin
                    res.num   = 2'd1;
                    res.tok0  = '{token_byte: held_byte_reg, token_last: 1'b1,
                                  token_quoted: 1'b0, token_empty: 1'b0};
                    mode_next = ctt_pkg::MODE_IDLE;
                end
            end

            ctt_pkg::MODE_QOPEN:
            begin
                if (c == ctt_pkg::CH_DQUOTE || c == ctt_pkg::CH_NUL)
                begin
                    // empty quoted token
                    res.num   = 2'd1;
                    res.tok0  = '{token_byte: 8'h00, token_last: 1'b1,
                                  token_quoted: 1'b1, token_empty: 1'b1};
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else
                begin
                    held_byte_next = c;
                    mode_next      = ctt_pkg::MODE_QUOTE;
                end
            end

            ctt_pkg::MODE_QUOTE:
            begin
                res.num = 2'd1;
                if (c == ctt_pkg::CH_DQUOTE || c == ctt_pkg::CH_NUL)
                begin
                    res.tok0  = '{token_byte: held_byte_reg, token_last: 1'b1,
                                  token_quoted: 1'b1, token_empty: 1'b0};
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else
                begin
                    res.tok0       = '{token_byte: held_byte_reg, token_last: 1'b0,
                                       token_quoted: 1'b1, token_empty: 1'b0};
                    held_byte_next = c;
                end
            end

            ctt_pkg::MODE_LINE:
            begin
                if (c == ctt_pkg::CH_LF || c == ctt_pkg::CH_NUL)
                begin
                    mode_next = ctt_pkg::MODE_IDLE;
                end
            end

            ctt_pkg::MODE_BLOCK:
            begin
                if (c == ctt_pkg::CH_NUL)
                begin
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else if (c == ctt_pkg::CH_STAR)
                begin
                    mode_next = ctt_pkg::MODE_BSTAR;
                end
            end

            ctt_pkg::MODE_BSTAR:
            begin
                if (c == ctt_pkg::CH_NUL || c == ctt_pkg::CH_SLASH)
                begin
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else if (c != ctt_pkg::CH_STAR)
                begin
                    mode_next = ctt_pkg::MODE_BLOCK;
                end
            end

            default:
            begin
                mode_next = ctt_pkg::MODE_IDLE;
            end
        endcase
    end

    // Drop results unless the byte is actually taken
    always_comb
    begin
        push = res;
        if (!fire)
        begin
            push.num = 2'd0;
        end
    end

    // Advance mode on each scanned byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ctt_pkg::MODE_IDLE;
            held_byte_reg <= 8'h00;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            held_byte_reg <= held_byte_next;
        end
    end

endmodule

// File: rtl/ctt_outq.sv
// Small result queue that takes up to two tokens per cycle and delivers one.
module ctt_outq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctt_pkg::push_t            push,
    input  logic                      pop,
    output logic                      room,
    output logic                      head_valid,
    output ctt_pkg::token_t           head
);

    ctt_pkg::token_t                  entry_reg [ctt_pkg::QDEPTH];
    logic [ctt_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ctt_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ctt_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic [ctt_pkg::QPTR_W-1:0]       wr_ptr_inc;
    logic                             do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign room       = (count_reg <= ctt_pkg::QCNT_W'(ctt_pkg::QDEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + ctt_pkg::QPTR_W'(1);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ctt_pkg::QPTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + ctt_pkg::QPTR_W'(do_pop);
        count_next  = count_reg + ctt_pkg::QCNT_W'(push.num)
                    - ctt_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed tokens in order
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.num == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.tok1;
        end
    end

endmodule

// File: rtl/config_text_tokenizer_core.sv
// Top level of the config text tokenizer: input register, scanner and result queue.
//
// Takes one text byte per cycle and streams out token bytes, one per cycle while
// token_stall is low. An accepted byte is registered in the input register, scanned
// against the mode machine, and its results enter a four-entry queue whose head drives
// the outputs. A byte normally yields zero or one result, so the block sustains one byte
// per cycle; a word closed by a one-character token yields two, and the input stalls
// whenever a byte waits in the input register and the queue has fewer than two free
// entries. The last byte of a word or quoted string comes out only when the next byte
// shows where the token ends, and a zero byte closes any open token or comment.
module config_text_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    output logic       token_valid,
    input  logic       token_stall,
    output logic [7:0] token_byte,
    output logic       token_last,
    output logic       token_quoted,
    output logic       token_empty
);

    logic            byte_valid_reg, byte_valid_next;
    logic [7:0]      byte_reg;
    logic            room;
    ctt_pkg::push_t  push;
    ctt_pkg::token_t head;

    // Hold the input byte until the scanner has room for its results
    assign text_stall      = byte_valid_reg && !room;
    assign byte_valid_next = text_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall && text_valid)
        begin
            byte_reg <= text_byte;
        end
    end

    ctt_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (byte_valid_reg),
        .item_byte  (byte_reg),
        .room       (room),
        .push       (push)
    );

    ctt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (!token_stall),
        .room       (room),
        .head_valid (token_valid),
        .head       (head)
    );

    assign token_byte   = head.token_byte;
    assign token_last   = head.token_last;
    assign token_quoted = head.token_quoted;
    assign token_empty  = head.token_empty;

endmodule

// File: rtl/ctt_checker.sv
// Port-level checks for the config text tokenizer, bound to the top level.
module ctt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_stall,
    input logic       token_valid,
    input logic       token_stall,
    input logic [7:0] token_byte,
    input logic       token_last,
    input logic       token_quoted,
    input logic       token_empty
);

    // Stalled request holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=>
            token_valid && $stable(token_byte) && $stable(token_last)
            && $stable(token_quoted) && $stable(token_empty))
    else $error("stalled token request changed");

    // Input stalls only while results are waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> token_valid)
    else $error("text request stalled with no token pending");

    // Empty token is a closed quoted token with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_empty |->
            token_quoted && token_last && token_byte == 8'h00)
    else $error("malformed empty token");

    // Unquoted token bytes never carry separators
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_quoted |->
            token_byte > ctt_pkg::CH_SPACE && token_byte < ctt_pkg::CH_HIGH)
    else $error("separator byte in unquoted token");

    // A non-final unquoted byte belongs to a word
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_quoted && !token_last |-> ctt_pkg::is_word(token_byte))
    else $error("one-character token not marked last");

endmodule

bind config_text_tokenizer_core ctt_checker u_ctt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_stall   (text_stall),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_byte   (token_byte),
    .token_last   (token_last),
    .token_quoted (token_quoted),
    .token_empty  (token_empty)
);
